// File: rtl/walled_grid_diffusion_stencil_assert.svh
// Assertion macros shared by the diffusion stencil RTL.
`ifndef WALLED_GRID_DIFFUSION_STENCIL_ASSERT_SVH
`define WALLED_GRID_DIFFUSION_STENCIL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WGDS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wgds: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define WGDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wgds: next-cycle check failed");

`endif

// File: rtl/wgds_pkg.sv
// Package: sizes, codes and types of the walled grid diffusion stencil.
`timescale 1ns / 1ps
package wgds_pkg;

    // Grid and data sizes
    localparam int LINE_DEPTH = 256;
    localparam int ROW_LIMIT  = 512;
    localparam int VALUE_BITS = 16;
    localparam int N_LANES    = 4;
    localparam int CHAN_BITS  = 16;

    localparam int COL_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int ROW_W = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;

    // Register field widths
    localparam int GC_BITS  = 9;
    localparam int GR_BITS  = 10;
    localparam int MIX_BITS = 16;

    // Arithmetic: weights are Q1.15, the four-neighbour mean adds two more bits
    localparam int ONE_Q15    = 32768;
    localparam int FRAC_SH    = 17;
    localparam int ROUND_HALF = 1 << (FRAC_SH - 1);
    localparam int SUM_W      = VALUE_BITS + 2;
    localparam int KEEP_W     = MIX_BITS + VALUE_BITS;
    localparam int MIXP_W     = MIX_BITS + SUM_W;
    localparam int NUM_W      = MIXP_W + 2;

    // APB port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_GRID_COLUMNS = 2'd0,
        REG_GRID_ROWS    = 2'd1,
        REG_MIX_FRACTION = 2'd2
    } t_reg_idx;

    // Input word kinds
    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef logic [VALUE_BITS-1:0] t_value;

    // One line-store entry: wall flag and the four channel values
    typedef struct packed {
        logic                                wall;
        logic [N_LANES-1:0][VALUE_BITS-1:0] chan;
    } t_cell;

    // Line-store control from the sequencer
    typedef struct packed {
        logic             step;
        logic             write;
        logic             wrap;
        logic [COL_W-1:0] col;
    } t_ls_ctrl;

    // Neighbour selection shared by all lanes
    typedef struct packed {
        logic self_wall;
        logic use_l;
        logic use_r;
        logic use_u;
        logic use_d;
    } t_nbr_sel;

    // Stage load enables for the lanes
    typedef struct packed {
        logic ld0;
        logic ld1;
    } t_lane_en;

    // Merged result word
    typedef struct packed {
        logic [N_LANES-1:0][CHAN_BITS-1:0] chan;
        logic                               frame_end;
    } t_result;

endpackage

// File: rtl/wgds_stream_if.sv
// Stream interfaces: grid cell words in, diffused result words out.
`timescale 1ns / 1ps
interface wgds_cell_if import wgds_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic                 is_wall;
    logic [CHAN_BITS-1:0] chan0_in;
    logic [CHAN_BITS-1:0] chan1_in;
    logic [CHAN_BITS-1:0] chan2_in;
    logic [CHAN_BITS-1:0] chan3_in;

    modport source (output valid, kind, is_wall, chan0_in, chan1_in, chan2_in, chan3_in,
                    input ready);
    modport sink (input valid, kind, is_wall, chan0_in, chan1_in, chan2_in, chan3_in,
                  output ready);
endinterface

interface wgds_result_if import wgds_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CHAN_BITS-1:0] chan0_out;
    logic [CHAN_BITS-1:0] chan1_out;
    logic [CHAN_BITS-1:0] chan2_out;
    logic [CHAN_BITS-1:0] chan3_out;
    logic                 frame_end;

    modport source (output valid, chan0_out, chan1_out, chan2_out, chan3_out, frame_end,
                    input ready);
    modport sink (input valid, chan0_out, chan1_out, chan2_out, chan3_out, frame_end,
                  output ready);
endinterface

// File: rtl/wgds_line_store.sv
// Two line stores with a prefetch window of self, right and upper entries.
`timescale 1ns / 1ps
module wgds_line_store import wgds_pkg::*; (
    input  logic     i_clk,
    input  t_ls_ctrl i_ctrl,
    input  t_cell    i_wdata,
    output t_cell    o_self,
    output t_cell    o_right,
    output t_cell    o_up
);

    t_cell r_tgt [LINE_DEPTH];
    t_cell r_upr [LINE_DEPTH];

    t_cell r_self;
    t_cell r_right;
    t_cell r_up;

    logic [COL_W-1:0] w_addr_b;
    logic [COL_W-1:0] w_addr_u;

    // Within a row the window slides by one; at a wrap it restarts at column zero
    assign w_addr_b = i_ctrl.wrap ? COL_W'(1) : i_ctrl.col + COL_W'(2);
    assign w_addr_u = i_ctrl.wrap ? '0 : i_ctrl.col + COL_W'(1);

    // Shift the current row entry up and store the new word
    always_ff @(posedge i_clk) begin
        if (i_ctrl.write) begin
            r_tgt[i_ctrl.col] <= i_wdata;
            r_upr[i_ctrl.col] <= r_self;
        end
    end

    // Advance the window, bypassing a write to the same entry
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            if (i_ctrl.wrap) begin
                r_self  <= (i_ctrl.write && i_ctrl.col == '0) ? i_wdata : r_tgt['0];
                r_right <= (i_ctrl.write && i_ctrl.col == COL_W'(1)) ? i_wdata
                                                                     : r_tgt[w_addr_b];
                r_up    <= (i_ctrl.write && i_ctrl.col == '0) ? r_self : r_upr[w_addr_u];
            end else begin
                r_self  <= r_right;
                r_right <= r_tgt[w_addr_b];
                r_up    <= r_upr[w_addr_u];
            end
        end
    end

    assign o_self  = r_self;
    assign o_right = r_right;
    assign o_up    = r_up;

endmodule

// File: rtl/wgds_lane.sv
// One channel lane: neighbour sum, weighted blend and rounding.
`timescale 1ns / 1ps
module wgds_lane import wgds_pkg::*; (
    input  logic                i_clk,
    input  t_lane_en            i_en,
    input  t_nbr_sel            i_sel,
    input  logic [MIX_BITS-1:0] i_mix,
    input  t_value              i_self,
    input  t_value              i_left,
    input  t_value              i_right,
    input  t_value              i_up,
    input  t_value              i_down,
    output t_value              o_res
);

    logic [SUM_W-1:0]    n_sum;
    logic [MIX_BITS-1:0] w_keep_wt;
    logic [NUM_W-1:0]    w_num;

    t_value              r_s0_self;
    logic [SUM_W-1:0]    r_s0_sum;
    logic                r_s0_wall;
    logic [MIX_BITS-1:0] r_s0_mix;

    logic [KEEP_W-1:0]   r_keep;
    logic [MIXP_W-1:0]   r_mixp;
    t_value              r_s1_self;
    logic                r_s1_wall;

    // Substitute self for absent or walled neighbours, then add
    always_comb begin
        n_sum = SUM_W'(i_sel.use_l ? i_left  : i_self)
              + SUM_W'(i_sel.use_r ? i_right : i_self)
              + SUM_W'(i_sel.use_u ? i_up    : i_self)
              + SUM_W'(i_sel.use_d ? i_down  : i_self);
    end

    // Capture operands
    always_ff @(posedge i_clk) begin
        if (i_en.ld0) begin
            r_s0_self <= i_self;
            r_s0_sum  <= n_sum;
            r_s0_wall <= i_sel.self_wall;
            r_s0_mix  <= i_mix;
        end
    end

    assign w_keep_wt = MIX_BITS'(ONE_Q15) - r_s0_mix;

    // Form both weighted products
    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_keep    <= KEEP_W'(w_keep_wt) * KEEP_W'(r_s0_self);
            r_mixp    <= MIXP_W'(r_s0_mix) * MIXP_W'(r_s0_sum);
            r_s1_self <= r_s0_self;
            r_s1_wall <= r_s0_wall;
        end
    end

    // Scale self by four, add, round half up and drop the fraction
    assign w_num = (NUM_W'(r_keep) << 2) + NUM_W'(r_mixp) + NUM_W'(ROUND_HALF);
    assign o_res = r_s1_wall ? r_s1_self : w_num[FRAC_SH +: VALUE_BITS];

endmodule

// File: rtl/wgds_merge.sv
// Merging stage: gathers the lane results into the registered output word.
`timescale 1ns / 1ps
module wgds_merge import wgds_pkg::*; (
    input  logic    i_clk,
    input  logic    i_load,
    input  t_value  i_lane_res [N_LANES],
    input  logic    i_frame_end,
    output t_result o_result
);

    t_result r_out;
    t_result n_out;

    // Widen each lane to the channel width and attach the frame flag
    always_comb begin
        for (int k = 0; k < N_LANES; k++) begin
            n_out.chan[k] = CHAN_BITS'(i_lane_res[k]);
        end
        n_out.frame_end = i_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

// File: rtl/walled_grid_diffusion_stencil.sv
// A word that releases a result passes the lane capture stage (r_v0), the product
// stage (r_v1) and the merge register (r_v2); it leaves when the output is ready.
// Throughput: one word per cycle while the output is ready. Four channel lanes work
// in parallel; prefetching the next column, the line stores never stall input.
// A cell is emitted one row after it arrives; drain words flush the last row.
// Reset (synchronous, active low) clears counters, drain flag, pipeline valids and
// the registers (columns 160, rows 512, mix 0); line-store contents are not cleared.
`timescale 1ns / 1ps
`include "walled_grid_diffusion_stencil_assert.svh"
module walled_grid_diffusion_stencil import wgds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    wgds_cell_if.sink         i_cell,
    wgds_result_if.source     o_result
);

    // Configuration registers
    logic [GC_BITS-1:0]  r_grid_columns;
    logic [GR_BITS-1:0]  r_grid_rows;
    logic [MIX_BITS-1:0] r_mix_fraction;

    logic                w_cfg_wr;
    t_reg_idx            w_reg_idx;

    // Sequencer state
    logic [COL_W-1:0]    r_column_count;
    logic [ROW_W-1:0]    r_row_count;
    logic                r_draining;
    t_cell               r_left;

    logic [COL_W-1:0]    w_cols_m1;
    logic [ROW_W-1:0]    w_rows_m1;
    logic [COL_W-1:0]    w_col;
    logic [ROW_W-1:0]    w_row;
    logic                w_last_col;
    logic                w_last_row;
    logic [MIX_BITS-1:0] w_mix;

    // Handshake and pipeline
    logic                w_is_drain;
    logic                w_acc;
    logic                w_cell_step;
    logic                w_drain_step;
    logic                w_step;
    logic                w_emit;
    logic                w_adv0;
    logic                w_adv1;
    logic                w_adv2;
    logic                r_v0;
    logic                r_v1;
    logic                r_v2;
    logic                r_fe0;
    logic                r_fe1;

    t_ls_ctrl            w_ls;
    t_cell               w_wdata;
    t_cell               w_self;
    t_cell               w_right;
    t_cell               w_up;
    t_nbr_sel            w_sel;
    t_lane_en            w_en;
    t_value              w_lane_res [N_LANES];
    t_result             w_out;

    // APB register file
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= GC_BITS'(160);
            r_grid_rows    <= GR_BITS'(512);
            r_mix_fraction <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_GRID_COLUMNS: r_grid_columns <= pwdata[GC_BITS-1:0];
                REG_GRID_ROWS:    r_grid_rows    <= pwdata[GR_BITS-1:0];
                REG_MIX_FRACTION: r_mix_fraction <= pwdata[MIX_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_GRID_COLUMNS: prdata = DATA_W'(r_grid_columns);
            REG_GRID_ROWS:    prdata = DATA_W'(r_grid_rows);
            REG_MIX_FRACTION: prdata = DATA_W'(r_mix_fraction);
            default:          prdata = '0;
        endcase
    end

    // Clamp the grid size and mix weight to their working ranges
    always_comb begin
        if (r_grid_columns == '0) begin
            w_cols_m1 = '0;
        end else if (32'(r_grid_columns) >= 32'(LINE_DEPTH)) begin
            w_cols_m1 = COL_W'(LINE_DEPTH - 1);
        end else begin
            w_cols_m1 = COL_W'(r_grid_columns - GC_BITS'(1));
        end
        if (r_grid_rows == '0) begin
            w_rows_m1 = '0;
        end else if (32'(r_grid_rows) >= 32'(ROW_LIMIT)) begin
            w_rows_m1 = ROW_W'(ROW_LIMIT - 1);
        end else begin
            w_rows_m1 = ROW_W'(r_grid_rows - GR_BITS'(1));
        end
        w_mix = (32'(r_mix_fraction) > 32'(ONE_Q15)) ? MIX_BITS'(ONE_Q15) : r_mix_fraction;
    end

    assign w_col      = (r_column_count > w_cols_m1) ? w_cols_m1 : r_column_count;
    assign w_row      = (r_row_count > w_rows_m1) ? w_rows_m1 : r_row_count;
    assign w_last_col = (w_col == w_cols_m1);
    assign w_last_row = (w_row == w_rows_m1);

    // Pipeline flow: a stage moves on when the next one is empty or moving
    assign w_adv2       = !r_v2 || o_result.ready;
    assign w_adv1       = !r_v1 || w_adv2;
    assign w_adv0       = !r_v0 || w_adv1;
    assign i_cell.ready = w_adv0;

    assign w_is_drain   = (i_cell.kind == KIND_DRAIN);
    assign w_acc        = i_cell.valid && w_adv0;
    assign w_cell_step  = w_acc && !w_is_drain && !r_draining;
    assign w_drain_step = w_acc && w_is_drain && r_draining;
    assign w_step       = w_cell_step || w_drain_step;
    assign w_emit       = (w_cell_step && r_row_count != '0) || w_drain_step;

    // Column, row and drain sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= '0;
            r_row_count    <= '0;
            r_draining     <= 1'b0;
        end else if (w_step) begin
            if (w_last_col) begin
                r_column_count <= '0;
                if (w_drain_step) begin
                    r_row_count <= '0;
                    r_draining  <= 1'b0;
                end else if (w_last_row) begin
                    r_row_count <= w_rows_m1;
                    r_draining  <= 1'b1;
                end else begin
                    r_row_count <= w_row + ROW_W'(1);
                end
            end else begin
                r_column_count <= w_col + COL_W'(1);
            end
        end
    end

    // Incoming word as a line-store entry
    assign w_wdata.wall    = i_cell.is_wall;
    assign w_wdata.chan[0] = i_cell.chan0_in[VALUE_BITS-1:0];
    assign w_wdata.chan[1] = i_cell.chan1_in[VALUE_BITS-1:0];
    assign w_wdata.chan[2] = i_cell.chan2_in[VALUE_BITS-1:0];
    assign w_wdata.chan[3] = i_cell.chan3_in[VALUE_BITS-1:0];

    assign w_ls.step  = w_step;
    assign w_ls.write = w_cell_step;
    assign w_ls.wrap  = w_last_col;
    assign w_ls.col   = w_col;

    wgds_line_store u_line_store (
        .i_clk   (i_clk),
        .i_ctrl  (w_ls),
        .i_wdata (w_wdata),
        .o_self  (w_self),
        .o_right (w_right),
        .o_up    (w_up)
    );

    // Hold the last emitted cell as the left neighbour
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_left <= w_self;
        end
    end

    // Neighbour selection for the emitted cell
    always_comb begin
        w_sel.self_wall = w_self.wall;
        w_sel.use_l     = (w_col != '0) && !r_left.wall;
        w_sel.use_r     = !w_last_col && !w_right.wall;
        w_sel.use_u     = (w_cell_step ? (r_row_count > ROW_W'(1)) : (r_row_count != '0))
                          && !w_up.wall;
        w_sel.use_d     = !w_is_drain && !i_cell.is_wall;
    end

    assign w_en.ld0 = w_adv0;
    assign w_en.ld1 = w_adv1;

    for (genvar k = 0; k < N_LANES; k++) begin : g_lane
        wgds_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_sel   (w_sel),
            .i_mix   (w_mix),
            .i_self  (w_self.chan[k]),
            .i_left  (r_left.chan[k]),
            .i_right (w_right.chan[k]),
            .i_up    (w_up.chan[k]),
            .i_down  (w_wdata.chan[k]),
            .o_res   (w_lane_res[k])
        );
    end

    // Valid and frame-end flags alongside the lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv0) begin
                r_v0 <= w_emit;
            end
            if (w_adv1) begin
                r_v1 <= r_v0;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv0) begin
            r_fe0 <= w_drain_step && w_last_col;
        end
        if (w_adv1) begin
            r_fe1 <= r_fe0;
        end
    end

    wgds_merge u_merge (
        .i_clk       (i_clk),
        .i_load      (w_adv2),
        .i_lane_res  (w_lane_res),
        .i_frame_end (r_fe1),
        .o_result    (w_out)
    );

    // Drive the result word
    assign o_result.valid     = r_v2;
    assign o_result.chan0_out = w_out.chan[0];
    assign o_result.chan1_out = w_out.chan[1];
    assign o_result.chan2_out = w_out.chan[2];
    assign o_result.chan3_out = w_out.chan[3];
    assign o_result.frame_end = w_out.frame_end;

    // A drain word outside a drain, or a cell word while draining, is dropped
    `WGDS_ASSERT_SAME(a_ignored_no_emit, i_clk, i_rst_n, w_acc && (w_is_drain != r_draining), !w_emit)
    // A word that releases a result enters the lane pipeline
    `WGDS_ASSERT_NEXT(a_emit_enters, i_clk, i_rst_n, w_emit, r_v0)
    // Cells of the first row are only stored
    `WGDS_ASSERT_NEXT(a_first_row_quiet, i_clk, i_rst_n, w_cell_step && (r_row_count == '0), !r_v0)
    // The last drain word of a frame rewinds the sequencer
    `WGDS_ASSERT_NEXT(a_frame_rewind, i_clk, i_rst_n, w_drain_step && w_last_col, (r_column_count == '0) && (r_row_count == '0) && !r_draining)

endmodule
